FILE: design/qar_pkg.sv
`default_nettype none
package qar_pkg;

	localparam int CORDIC_STEPS_DEF = 24;

	localparam logic [2:0] MODE_PRE     = 3'd0;
	localparam logic [2:0] MODE_POST    = 3'd1;
	localparam logic [2:0] MODE_MAKEROT = 3'd2;
	localparam logic [2:0] MODE_PREROT  = 3'd3;
	localparam logic [2:0] MODE_POSTROT = 3'd4;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [31:0] Q_ONE = 32'sd1073741824;

	typedef struct packed {
		logic [1:0] pi;
		logic [1:0] qi;
		logic       neg;
	} ham_term_t;

	// Term k of component c of the Hamilton product p*q, index {c, k}.
	function automatic ham_term_t ham_term(input logic [3:0] idx);
		ham_term_t t;
		case (idx)
			4'd0:  t = '{2'd0, 2'd3, 1'b0};
			4'd1:  t = '{2'd3, 2'd0, 1'b0};
			4'd2:  t = '{2'd1, 2'd2, 1'b0};
			4'd3:  t = '{2'd2, 2'd1, 1'b1};
			4'd4:  t = '{2'd1, 2'd3, 1'b0};
			4'd5:  t = '{2'd3, 2'd1, 1'b0};
			4'd6:  t = '{2'd2, 2'd0, 1'b0};
			4'd7:  t = '{2'd0, 2'd2, 1'b1};
			4'd8:  t = '{2'd2, 2'd3, 1'b0};
			4'd9:  t = '{2'd3, 2'd2, 1'b0};
			4'd10: t = '{2'd0, 2'd1, 1'b0};
			4'd11: t = '{2'd1, 2'd0, 1'b1};
			4'd12: t = '{2'd3, 2'd3, 1'b0};
			4'd13: t = '{2'd0, 2'd0, 1'b1};
			4'd14: t = '{2'd1, 2'd1, 1'b1};
			default: t = '{2'd2, 2'd2, 1'b1};
		endcase
		return t;
	endfunction

	// Arctangent step angles in units of 2^-33 turn.
	function automatic logic [31:0] atan_step(input logic [4:0] k);
		logic [31:0] v;
		case (k)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			5'd24: v = 32'd41;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			5'd28: v = 32'd3;
			5'd29: v = 32'd1;
			5'd30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return {v[30:0], 1'b0};
	endfunction

endpackage
`default_nettype wire

FILE: design/qar_in_if.sv
`default_nettype none
interface qar_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic signed [31:0] opnd_x;
	logic signed [31:0] opnd_y;
	logic signed [31:0] opnd_z;
	logic signed [31:0] opnd_w;
	logic [31:0]        turn_angle;

	modport source (output valid, mode, opnd_x, opnd_y, opnd_z, opnd_w, turn_angle,
		input ready);
	modport sink (input valid, mode, opnd_x, opnd_y, opnd_z, opnd_w, turn_angle,
		output ready);
endinterface
`default_nettype wire

FILE: design/qar_out_if.sv
`default_nettype none
interface qar_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] res_x;
	logic signed [31:0] res_y;
	logic signed [31:0] res_z;
	logic signed [31:0] res_w;
	logic               sat_flag;

	modport source (output valid, res_x, res_y, res_z, res_w, sat_flag, input ready);
	modport sink (input valid, res_x, res_y, res_z, res_w, sat_flag, output ready);
endinterface
`default_nettype wire

FILE: design/quaternion_accumulate_rotate.sv
`default_nettype none
// Channel  Role    Payload
// in_ch    sink    mode, opnd_x/y/z/w, turn_angle
// out_ch   source  res_x/y/z/w, sat_flag
//
// Multiply modes run sixteen products through the one 32x32 multiplier, drain
// the product register, leave the product loop and then load the output
// register. Rotation modes first run the CORDIC and the axis scaling, then the
// products (make-rotation skips the products).
// Reset leaves the identity quaternion in the store. in_ch is ready only while
// the sequencer is idle; a stalled output holds the finished item in place.
module quaternion_accumulate_rotate #(
	parameter int CORDIC_STEPS = qar_pkg::CORDIC_STEPS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	qar_in_if.sink    in_ch,
	qar_out_if.source out_ch
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CORD  = 3'd1;
	localparam logic [2:0] S_SCALE = 3'd2;
	localparam logic [2:0] S_HAM   = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]         state_q;
	logic [2:0]         mode_q;
	logic [31:0]        angle_q;
	logic signed [31:0] op_q [4];
	logic signed [31:0] store_q [4];
	logic signed [31:0] rot_q [4];
	logic signed [31:0] res_q [4];
	logic               flag_q;
	logic [4:0]         cnt_q;
	logic signed [66:0] acc_q;

	logic               v_s1, neg_s1, last_s1;
	logic [1:0]         dst_s1;
	logic signed [63:0] prod_s1;

	logic               out_valid_q;
	logic signed [31:0] out_q [4];
	logic               out_flag_q;

	logic               cord_start_q, cord_done;
	logic signed [31:0] sin_v;
	logic signed [33:0] cos_v;

	logic                 accept;
	logic                 issue;
	logic signed [31:0]   mul_a, mul_b;
	logic                 mul_neg, mul_last;
	logic [1:0]           mul_dst;
	qar_pkg::ham_term_t   tm;
	logic signed [66:0]   term, sum;
	logic signed [66:0]   rnd;
	logic signed [31:0]   rnd_sat;
	logic                 rnd_ovf;
	logic signed [31:0]   cos_sat;
	logic                 cos_ovf;
	logic                 out_free;

	qar_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start_q),
		.angle  (angle_q),
		.done   (cord_done),
		.sin_v  (sin_v),
		.cos_v  (cos_v)
	);

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept      = in_ch.valid && (state_q == S_IDLE);
	assign out_free    = !out_valid_q || out_ch.ready;

	always_comb begin
		tm       = qar_pkg::ham_term(cnt_q[3:0]);
		mul_a    = '0;
		mul_b    = '0;
		mul_neg  = 1'b0;
		mul_last = 1'b1;
		mul_dst  = cnt_q[1:0];
		issue    = 1'b0;
		if (state_q == S_SCALE) begin
			issue = (cnt_q < 5'd3);
			mul_a = op_q[cnt_q[1:0]];
			mul_b = sin_v;
		end else if (state_q == S_HAM) begin
			issue    = !cnt_q[4];
			mul_neg  = tm.neg;
			mul_last = (cnt_q[1:0] == 2'd3);
			mul_dst  = cnt_q[3:2];
			if (mode_q == qar_pkg::MODE_PRE) begin
				mul_a = op_q[tm.pi];
			end else if (mode_q == qar_pkg::MODE_PREROT) begin
				mul_a = rot_q[tm.pi];
			end else begin
				mul_a = store_q[tm.pi];
			end
			if (mode_q == qar_pkg::MODE_POST) begin
				mul_b = op_q[tm.qi];
			end else if (mode_q == qar_pkg::MODE_POSTROT) begin
				mul_b = rot_q[tm.qi];
			end else begin
				mul_b = store_q[tm.qi];
			end
		end
	end

	// Exact sum of products, then round half up at bit 30 and saturate.
	always_comb begin
		term    = neg_s1 ? -67'(prod_s1) : 67'(prod_s1);
		sum     = acc_q + term;
		rnd     = (sum + 67'sd536870912) >>> 30;
		rnd_ovf = (rnd > 67'sd2147483647) || (rnd < -67'sd2147483648);
		if (rnd > 67'sd2147483647) begin
			rnd_sat = 32'sh7FFFFFFF;
		end else if (rnd < -67'sd2147483648) begin
			rnd_sat = 32'sh80000000;
		end else begin
			rnd_sat = rnd[31:0];
		end
		cos_ovf = (cos_v > 34'sd2147483647) || (cos_v < -34'sd2147483648);
		if (cos_v > 34'sd2147483647) begin
			cos_sat = 32'sh7FFFFFFF;
		end else if (cos_v < -34'sd2147483648) begin
			cos_sat = 32'sh80000000;
		end else begin
			cos_sat = cos_v[31:0];
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		neg_s1  <= mul_neg;
		last_s1 <= mul_last;
		dst_s1  <= mul_dst;
		if (accept) begin
			mode_q  <= in_ch.mode;
			angle_q <= in_ch.turn_angle;
			op_q[0] <= in_ch.opnd_x;
			op_q[1] <= in_ch.opnd_y;
			op_q[2] <= in_ch.opnd_z;
			op_q[3] <= in_ch.opnd_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cord_start_q <= 1'b0;
			cnt_q        <= '0;
			acc_q        <= '0;
			v_s1         <= 1'b0;
			flag_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			out_flag_q   <= 1'b0;
			for (int j = 0; j < 4; j++) begin
				store_q[j] <= '0;
				rot_q[j]   <= '0;
				res_q[j]   <= '0;
				out_q[j]   <= '0;
			end
			store_q[3] <= qar_pkg::Q_ONE;
		end else begin
			cord_start_q <= 1'b0;
			v_s1         <= issue;
			if (issue) begin
				cnt_q <= cnt_q + 5'd1;
			end
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (v_s1) begin
				if (last_s1) begin
					acc_q  <= '0;
					flag_q <= flag_q | rnd_ovf;
					if (state_q == S_SCALE) begin
						rot_q[dst_s1] <= rnd_sat;
					end else begin
						res_q[dst_s1] <= rnd_sat;
					end
				end else begin
					acc_q <= sum;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						flag_q <= 1'b0;
						cnt_q  <= '0;
						acc_q  <= '0;
						if (in_ch.mode == qar_pkg::MODE_PRE ||
							in_ch.mode == qar_pkg::MODE_POST) begin
							state_q <= S_HAM;
						end else if (in_ch.mode == qar_pkg::MODE_MAKEROT ||
							in_ch.mode == qar_pkg::MODE_PREROT ||
							in_ch.mode == qar_pkg::MODE_POSTROT) begin
							state_q      <= S_CORD;
							cord_start_q <= 1'b1;
						end else begin
							// Unused mode codes return the store unchanged.
							for (int j = 0; j < 4; j++) begin
								res_q[j] <= store_q[j];
							end
							state_q <= S_DONE;
						end
					end
				end
				S_CORD: begin
					if (cord_done) begin
						rot_q[3] <= cos_sat;
						flag_q   <= flag_q | cos_ovf;
						cnt_q    <= '0;
						state_q  <= S_SCALE;
					end
				end
				S_SCALE: begin
					if (cnt_q == 5'd3 && !v_s1) begin
						cnt_q <= '0;
						if (mode_q == qar_pkg::MODE_MAKEROT) begin
							for (int j = 0; j < 4; j++) begin
								res_q[j] <= rot_q[j];
							end
							state_q <= S_DONE;
						end else begin
							state_q <= S_HAM;
						end
					end
				end
				S_HAM: begin
					if (cnt_q[4] && !v_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						for (int j = 0; j < 4; j++) begin
							out_q[j]   <= res_q[j];
							store_q[j] <= res_q[j];
						end
						out_flag_q  <= flag_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.res_x    = out_q[0];
	assign out_ch.res_y    = out_q[1];
	assign out_ch.res_z    = out_q[2];
	assign out_ch.res_w    = out_q[3];
	assign out_ch.sat_flag = out_flag_q;
endmodule
`default_nettype wire

FILE: design/qar_cordic.sv
`default_nettype none
module qar_cordic #(
	parameter int CORDIC_STEPS = qar_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [31:0]        angle,
	output logic                    done,
	output logic signed [31:0]      sin_v,
	output logic signed [33:0]      cos_v
);
	logic signed [33:0] x_q, y_q, z_q;
	logic               upper_q;
	logic               busy_q;
	logic               done_q;
	logic [5:0]         i_q;
	logic [4:0]         k;
	logic signed [33:0] dx, dy, t;

	assign k  = i_q[4:0];
	assign dx = y_q >>> k;
	assign dy = x_q >>> k;
	assign t  = $signed({2'b00, qar_pkg::atan_step(k)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 6'd1;
				if (i_q == 6'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q     <= qar_pkg::CORDIC_GAIN;
			y_q     <= '0;
			z_q     <= $signed({3'b000, angle[30:0]});
			upper_q <= angle[31];
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - t;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + t;
			end
		end
	end

	// From pi/2 upward the rotation ran on the angle less a quarter turn.
	assign sin_v = upper_q ? x_q[31:0] : y_q[31:0];
	assign cos_v = upper_q ? -y_q : x_q;
	assign done  = done_q;
endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

	localparam int WATCHDOG = 4000;
	localparam int N_RANDOM = 630;

	// Mode codes with no operation behind them.
	localparam logic [2:0] MODE_RSVD_LO  = 3'd5;
	localparam logic [2:0] MODE_RSVD_MID = 3'd6;
	localparam logic [2:0] MODE_RSVD_HI  = 3'd7;

	typedef struct {
		logic [2:0]         mode;
		logic signed [31:0] x, y, z, w;
		logic [31:0]        angle;
		bit                 has_exp;
		logic signed [31:0] ex, ey, ez, ew;
		logic               esat;
	} stim_row_t;

	typedef struct {
		logic signed [31:0] x, y, z, w;
		logic               sat;
	} quat_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qar_in_if  in_ch();
	qar_out_if out_ch();

	quaternion_accumulate_rotate u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predicted store contents, in 64-bit signed for headroom.
	longint quat_q[4];
	quat_res_t product_queue[$];
	int mismatches = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_sat = 0;
	int idle_cycles = 0;
	bit stim_done = 0;
	bit hold_off = 0;

	function automatic longint shr_floor(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint clamp32(longint v, ref bit flag);
		if (v > 64'sd2147483647) begin
			flag = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			flag = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// Exact Hamilton product with a split accumulator, rounded once per component.
	function automatic void hamilton_mul(input longint p[4], input longint q[4],
			output longint r[4], ref bit flag);
		int pi_t[16] = '{0,3,1,2, 1,3,2,0, 2,3,0,1, 3,0,1,2};
		int qi_t[16] = '{3,0,2,1, 3,1,0,2, 3,2,1,0, 3,0,1,2};
		bit ng_t[16] = '{0,0,0,1, 0,0,0,1, 0,0,0,1, 0,1,1,1};
		longint hi, lo, prod;
		for (int c = 0; c < 4; c++) begin
			hi = 0;
			lo = 0;
			for (int k = 0; k < 4; k++) begin
				prod = p[pi_t[4*c+k]] * q[qi_t[4*c+k]];
				if (ng_t[4*c+k]) prod = -prod;
				hi += shr_floor(prod, 30);
				lo += prod & 64'h3FFF_FFFF;
			end
			r[c] = clamp32(hi + shr_floor(lo + 64'sd536870912, 30), flag);
		end
	endfunction

	function automatic void half_angle_sincos(input logic [31:0] angle,
			output longint s, output longint c);
		longint atan_units[32] = '{536870912, 316933406, 167458907, 85004756,
			42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
			333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652,
			326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
		longint cx, cy, cz, dx, dy;
		cx = 652032874;
		cy = 0;
		cz = longint'(angle[30:0]);
		for (int i = 0; i < qar_pkg::CORDIC_STEPS_DEF; i++) begin
			dx = shr_floor(cy, i % 32);
			dy = shr_floor(cx, i % 32);
			if (cz >= 0) begin
				cx -= dx; cy += dy; cz -= 2 * atan_units[i % 32];
			end else begin
				cx += dx; cy -= dy; cz += 2 * atan_units[i % 32];
			end
		end
		if (angle[31]) begin
			s = cx; c = -cy;
		end else begin
			s = cy; c = cx;
		end
	endfunction

	function automatic quat_res_t predict_update(stim_row_t r);
		longint opq[4], rot[4], nq[4], s, c;
		bit flag;
		quat_res_t o;
		flag = 0;
		opq = '{longint'(r.x), longint'(r.y), longint'(r.z), longint'(r.w)};
		if (r.mode inside {qar_pkg::MODE_MAKEROT, qar_pkg::MODE_PREROT,
				qar_pkg::MODE_POSTROT}) begin
			half_angle_sincos(r.angle, s, c);
			for (int j = 0; j < 3; j++)
				rot[j] = clamp32(shr_floor(opq[j] * s + 64'sd536870912, 30), flag);
			rot[3] = clamp32(c, flag);
		end
		case (r.mode)
			qar_pkg::MODE_PRE:     hamilton_mul(opq, quat_q, nq, flag);
			qar_pkg::MODE_POST:    hamilton_mul(quat_q, opq, nq, flag);
			qar_pkg::MODE_MAKEROT: nq = rot;
			qar_pkg::MODE_PREROT:  hamilton_mul(rot, quat_q, nq, flag);
			qar_pkg::MODE_POSTROT: hamilton_mul(quat_q, rot, nq, flag);
			default: begin
				nq = quat_q;
				flag = 0;
			end
		endcase
		quat_q = nq;
		o.x = nq[0][31:0];
		o.y = nq[1][31:0];
		o.z = nq[2][31:0];
		o.w = nq[3][31:0];
		o.sat = flag;
		return o;
	endfunction

	function automatic stim_row_t mk(logic [2:0] m, logic [31:0] x, logic [31:0] y,
			logic [31:0] z, logic [31:0] w, logic [31:0] a);
		stim_row_t r;
		r.mode = m; r.x = x; r.y = y; r.z = z; r.w = w; r.angle = a;
		r.has_exp = 0;
		r.ex = 0; r.ey = 0; r.ez = 0; r.ew = 0; r.esat = 0;
		return r;
	endfunction

	function automatic stim_row_t mk_exp(stim_row_t r, logic [31:0] x, logic [31:0] y,
			logic [31:0] z, logic [31:0] w, logic s);
		r.has_exp = 1;
		r.ex = x; r.ey = y; r.ez = z; r.ew = w; r.esat = s;
		return r;
	endfunction

	function automatic logic [31:0] rnd_comp();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 1) ? qar_pkg::Q_ONE : -qar_pkg::Q_ONE;
			default: return $urandom();
		endcase
	endfunction

	stim_row_t directed[$];
	quat_res_t expected_res;

	// Valid stays up after an accepted request and drops only for an idle gap.
	task automatic send_request(stim_row_t r);
		int gap;
		quat_res_t p;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= r.mode;
		in_ch.opnd_x <= r.x;
		in_ch.opnd_y <= r.y;
		in_ch.opnd_z <= r.z;
		in_ch.opnd_w <= r.w;
		in_ch.turn_angle <= r.angle;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		p = predict_update(r);
		if (r.has_exp && (p.x !== r.ex || p.y !== r.ey || p.z !== r.ez
				|| p.w !== r.ew || p.sat !== r.esat))
			$display("note: table row disagrees with prediction, mode %0d", r.mode);
		if (r.has_exp) begin
			p.x = r.ex; p.y = r.ey; p.z = r.ez; p.w = r.ew; p.sat = r.esat;
		end
		product_queue.push_back(p);
		n_sent++;
		@(negedge clk);
	endtask

	initial begin
		stim_row_t r;
		in_ch.valid = 1'b0;
		in_ch.mode = qar_pkg::MODE_PRE;
		in_ch.opnd_x = 0;
		in_ch.opnd_y = 0;
		in_ch.opnd_z = 0;
		in_ch.opnd_w = 0;
		in_ch.turn_angle = 0;
		quat_q = '{0, 0, 0, longint'(qar_pkg::Q_ONE)};

		// Unused mode right after reset returns the identity.
		directed.push_back(mk_exp(mk(MODE_RSVD_LO, 1, 2, 3, 4, 5), 0, 0, 0,
			qar_pkg::Q_ONE, 0));
		directed.push_back(mk_exp(mk(qar_pkg::MODE_PRE, 10, -20, 30, qar_pkg::Q_ONE, 0),
			10, -20, 30, qar_pkg::Q_ONE, 0));
		directed.push_back(mk(qar_pkg::MODE_POST, 0, qar_pkg::Q_ONE, 0, 0, 0));
		directed.push_back(mk(MODE_RSVD_MID, 0, 0, 0, 0, 0));
		directed.push_back(mk(qar_pkg::MODE_MAKEROT, qar_pkg::Q_ONE, 0, 0, 0,
			32'h4000_0000));
		directed.push_back(mk(qar_pkg::MODE_MAKEROT, 0, 0, qar_pkg::Q_ONE, 0,
			32'h0000_0000));
		directed.push_back(mk(qar_pkg::MODE_MAKEROT, 0, qar_pkg::Q_ONE, 0, 0,
			32'h8000_0000));
		directed.push_back(mk(qar_pkg::MODE_PREROT, 0, 0, qar_pkg::Q_ONE, 0,
			32'hFFFF_FFFF));
		directed.push_back(mk(qar_pkg::MODE_POSTROT, qar_pkg::Q_ONE, 0, 0, 0,
			32'h7FFF_FFFF));
		// Axis far from unit length, its components at the ends of the range.
		directed.push_back(mk(qar_pkg::MODE_MAKEROT, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 0, 32'hC000_0000));
		directed.push_back(mk(qar_pkg::MODE_PRE, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
		directed.push_back(mk(qar_pkg::MODE_POST, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF));
		directed.push_back(mk(MODE_RSVD_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF));
		directed.push_back(mk(qar_pkg::MODE_MAKEROT, qar_pkg::Q_ONE, qar_pkg::Q_ONE,
			qar_pkg::Q_ONE, 0, 32'h2000_0000));
		directed.push_back(mk(qar_pkg::MODE_POSTROT, 0, 0, 0, 0, 32'h1234_5678));
		directed.push_back(mk(qar_pkg::MODE_PREROT, -qar_pkg::Q_ONE, 0, 0,
			32'h7FFF_FFFF, 32'hA000_0000));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) send_request(directed[i]);

		for (int n = 0; n < N_RANDOM; n++) begin
			r = mk($urandom_range(0, 9) == 0
				? 3'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI))
				: 3'($urandom_range(qar_pkg::MODE_PRE, qar_pkg::MODE_POSTROT)),
				rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), $urandom());
			// Most requests use operands of at most one half in magnitude so the store stays in range.
			if ($urandom_range(0, 3) != 0) begin
				r.x = $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
				r.y = $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
				r.z = $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
				r.w = $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
			end
			if (n == 100) hold_off = 1;
			send_request(r);
		end
		in_ch.valid <= 1'b0;
		stim_done = 1;
	end

	// Receiver: random stalls, plus one long hold-off while requests keep coming.
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ch.ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_off = 0;
			end
			stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
				@(negedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (product_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result x=%h", out_ch.res_x);
			end else begin
				expected_res = product_queue.pop_front();
				n_checked++;
				if (out_ch.sat_flag) n_sat++;
				if (out_ch.res_x !== expected_res.x || out_ch.res_y !== expected_res.y
						|| out_ch.res_z !== expected_res.z
						|| out_ch.res_w !== expected_res.w
						|| out_ch.sat_flag !== expected_res.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch #%0d exp %h %h %h %h s%b got %h %h %h %h s%b",
							n_checked, expected_res.x, expected_res.y, expected_res.z,
							expected_res.w, expected_res.sat, out_ch.res_x,
							out_ch.res_y, out_ch.res_z, out_ch.res_w,
							out_ch.sat_flag);
				end
			end
		end
	end

	// Watchdog on cycles with no accepted request in either direction.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		wait (product_queue.size() == 0);
		repeat (100) @(posedge clk);
		$display("Sent %0d requests, checked %0d results, %0d with saturation.",
			n_sent, n_checked, n_sat);
		if (mismatches == 0 && product_queue.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
